FILE: hdl/tarc_pkg.sv
// Shared types, constants and helpers for the tape audio range classifier.
// No dependencies; imported by every module in hdl/.
`default_nettype none

package tarc_pkg;

    // Field widths of the stream payloads
    localparam int SAMPLE_W   = 16;
    localparam int OUT_W      = 32;
    localparam int LEVEL_W    = 15;
    localparam int PLEN_W     = 16;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam int INDEX_BITS_DEF = 32;
    localparam int RES_FIFO_DEPTH = 4;

    // Register reset values
    localparam logic [LEVEL_W-1:0] QUIET_LEVEL_RST   = 15'd1843;
    localparam logic [PLEN_W-1:0]  MAX_PULSE_LEN_RST = 16'd110;   // 44100 / 400
    localparam logic [LEVEL_W-1:0] MIN_SLOPE_RST     = 15'd921;   // 1843 / 2

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_QUIET_LEVEL   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_PULSE_LEN = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_SLOPE     = 2'd2;

    typedef enum logic [1:0] {
        MODE_START,
        MODE_DATA,
        MODE_SILENCE
    } mode_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] quiet_level;
        logic [PLEN_W-1:0]  max_pulse_len;
        logic [LEVEL_W-1:0] min_slope;
    } cfg_t;

    typedef struct packed {
        logic             last_of_run;
        logic             stream_final;
        logic             is_data;
        logic [OUT_W-1:0] pulse_count;
        logic [OUT_W-1:0] range_end;
        logic [OUT_W-1:0] range_start;
    } res_t;

    function automatic logic [OUT_W-1:0] sat_inc(input logic [OUT_W-1:0] v);
        sat_inc = (v == '1) ? v : v + OUT_W'(1);
    endfunction

    function automatic res_t mk_res(input logic [OUT_W-1:0] start_idx,
                                    input logic [OUT_W-1:0] end_idx,
                                    input logic [OUT_W-1:0] cnt,
                                    input logic             dat,
                                    input logic             fin);
        res_t r;
        r.range_start  = start_idx;
        r.range_end    = end_idx;
        r.pulse_count  = cnt;
        r.is_data      = dat;
        r.stream_final = fin;
        r.last_of_run  = 1'b0;
        mk_res = r;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/tarc_core.sv
// Per-sample classification step: stream state registers and the range decision.
// Depends on tarc_pkg. Produces up to two results per stepped sample.
`default_nettype none

module tarc_core #(
    parameter int INDEX_BITS = tarc_pkg::INDEX_BITS_DEF
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire tarc_pkg::cfg_t                       cfg,
    input  wire logic                                 step,
    input  wire logic signed [tarc_pkg::SAMPLE_W-1:0] sample,
    input  wire logic                                 stream_end,
    output tarc_pkg::res_t                            res0,
    output tarc_pkg::res_t                            res1,
    output logic [1:0]                                res_cnt
);
    import tarc_pkg::*;

    localparam logic [INDEX_BITS-1:0] IDX_MAX = '1;

    mode_t                  mode_reg, mode_next;
    logic [INDEX_BITS-1:0]  idx_reg, rb_reg, pb_reg;
    logic [OUT_W-1:0]       ps_reg;
    logic                   pp_reg, ra_reg, fa_reg;
    logic signed [SAMPLE_W-1:0] prev_reg;

    logic [INDEX_BITS-1:0]  rb, pb, nxt;
    logic [OUT_W-1:0]       ps;
    logic                   pp, ra, fa;
    logic signed [SAMPLE_W-1:0] prev;
    logic                   run_data, over;
    logic [1:0]             n;
    res_t                   res [2];

    logic signed [17:0]     s_x, lvl_x, ms_x, prev_x;
    logic                   pos, loud, rise, fall, ends;

    assign s_x    = 18'(sample);
    assign lvl_x  = signed'({3'b000, cfg.quiet_level});
    assign ms_x   = signed'({3'b000, cfg.min_slope});
    assign prev_x = 18'(prev_reg);
    assign pos    = s_x > 18'sd0;
    assign loud   = (s_x > lvl_x) || (s_x < -lvl_x);
    assign nxt    = (idx_reg == IDX_MAX) ? idx_reg : idx_reg + INDEX_BITS'(1);

    // Datapath of one step
    always_comb begin
        rb       = rb_reg;
        pb       = pb_reg;
        ps       = ps_reg;
        pp       = pp_reg;
        prev     = prev_reg;
        ra       = ra_reg;
        fa       = fa_reg;
        n        = 2'd0;
        res[0]   = '0;
        res[1]   = '0;
        run_data = 1'b0;
        over     = 1'b0;
        rise     = 1'b0;
        fall     = 1'b0;
        ends     = 1'b0;

        case (mode_reg)
            MODE_DATA: begin
                run_data = 1'b1;
            end
            MODE_SILENCE: begin
                ends = pp_reg ? (s_x < -lvl_x) : (s_x > lvl_x);
                if (ends) begin
                    res[n[0]] = mk_res(OUT_W'(rb_reg), OUT_W'(idx_reg), OUT_W'(1), 1'b0, 1'b0);
                    n = n + 2'd1;
                    rb = idx_reg;
                    pb = idx_reg;
                    ps = '0;
                    pp = pos;
                    run_data = 1'b1;
                end else if (stream_end) begin
                    res[n[0]] = mk_res(OUT_W'(rb_reg), OUT_W'(nxt), OUT_W'(1), 1'b0, 1'b1);
                    n = n + 2'd1;
                end
            end
            default: begin
                if (idx_reg == '0) begin
                    if (loud) begin
                        rb = '0;
                        pb = '0;
                        ps = '0;
                        pp = pos;
                        run_data = 1'b1;
                    end else begin
                        prev = sample;
                        pp = pos;
                        pb = '0;
                        ps = '0;
                        if (stream_end) begin
                            res[n[0]] = mk_res('0, OUT_W'(nxt), OUT_W'(1), 1'b0, 1'b1);
                            n = n + 2'd1;
                        end
                    end
                end else begin
                    rise = ra_reg && (s_x >= prev_x + ms_x);
                    fall = fa_reg && (s_x <= prev_x - ms_x);
                    if ((rise || fall) && (pos != pp_reg)) begin
                        ps = sat_inc(ps_reg);
                        pb = idx_reg;
                        pp = pos;
                    end
                    if ((rise && s_x > lvl_x) || (fall && s_x < -lvl_x)) begin
                        // fast start: data from 0, or here if a pulse came late
                        if (ps != '0 && pb > INDEX_BITS'(cfg.max_pulse_len)) begin
                            res[n[0]] = mk_res('0, OUT_W'(idx_reg), OUT_W'(1), 1'b0, 1'b0);
                            n = n + 2'd1;
                            rb = idx_reg;
                            pb = idx_reg;
                            ps = '0;
                            pp = pos;
                        end else begin
                            rb = '0;
                        end
                        run_data = 1'b1;
                    end else if (loud) begin
                        res[n[0]] = mk_res('0, OUT_W'(idx_reg), OUT_W'(1), 1'b0, 1'b0);
                        n = n + 2'd1;
                        rb = idx_reg;
                        pb = idx_reg;
                        ps = '0;
                        pp = pos;
                        run_data = 1'b1;
                    end else begin
                        prev = sample;
                        ra = rise;
                        fa = fall;
                        if (stream_end) begin
                            res[n[0]] = mk_res('0, OUT_W'(nxt), OUT_W'(1), 1'b0, 1'b1);
                            n = n + 2'd1;
                        end
                    end
                end
            end
        endcase

        // Data-mode pulse tracking
        if (run_data) begin
            if (pos != pp) begin
                ps = sat_inc(ps);
                pb = idx_reg;
                pp = pos;
            end
            over = (nxt - pb) > INDEX_BITS'(cfg.max_pulse_len);
            if (over) begin
                if (ps != '0) begin
                    res[n[0]] = mk_res(OUT_W'(rb), OUT_W'(pb), ps, 1'b1, 1'b0);
                    n = n + 2'd1;
                end
                rb = pb;
                if (stream_end) begin
                    res[n[0]] = mk_res(OUT_W'(rb), OUT_W'(nxt), OUT_W'(1), 1'b0, 1'b1);
                    n = n + 2'd1;
                end
            end else if (stream_end) begin
                res[n[0]] = mk_res(OUT_W'(rb), OUT_W'(nxt), sat_inc(ps), 1'b1, 1'b1);
                n = n + 2'd1;
            end
        end

        if (n == 2'd1) begin
            res[0].last_of_run = 1'b1;
        end else if (n == 2'd2) begin
            res[1].last_of_run = 1'b1;
        end
    end

    // Mode next state
    always_comb begin
        mode_next = mode_reg;
        if (stream_end) begin
            mode_next = MODE_START;
        end else if (run_data) begin
            mode_next = over ? MODE_SILENCE : MODE_DATA;
        end
    end

    // Outputs
    always_comb begin
        res0    = res[0];
        res1    = res[1];
        res_cnt = step ? n : 2'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_START;
            idx_reg  <= '0;
            rb_reg   <= '0;
            pb_reg   <= '0;
            ps_reg   <= '0;
            pp_reg   <= 1'b0;
            prev_reg <= '0;
            ra_reg   <= 1'b1;
            fa_reg   <= 1'b1;
        end else if (step) begin
            mode_reg <= mode_next;
            if (stream_end) begin
                idx_reg  <= '0;
                rb_reg   <= '0;
                pb_reg   <= '0;
                ps_reg   <= '0;
                pp_reg   <= 1'b0;
                prev_reg <= '0;
                ra_reg   <= 1'b1;
                fa_reg   <= 1'b1;
            end else begin
                idx_reg  <= nxt;
                rb_reg   <= rb;
                pb_reg   <= pb;
                ps_reg   <= ps;
                pp_reg   <= pp;
                prev_reg <= prev;
                ra_reg   <= ra;
                fa_reg   <= fa;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hdl/tarc_res_fifo.sv
// Result queue: takes up to two results a cycle, hands out one per transfer.
// Depends on tarc_pkg for the result type and depth.
`default_nettype none

module tarc_res_fifo (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire tarc_pkg::res_t push0,
    input  wire tarc_pkg::res_t push1,
    input  wire logic [1:0]     push_cnt,
    output logic                room2,
    output logic                out_valid,
    input  wire logic           out_ready,
    output tarc_pkg::res_t      out_res
);
    import tarc_pkg::*;

    localparam int PTR_W = $clog2(RES_FIFO_DEPTH);
    localparam int CNT_W = $clog2(RES_FIFO_DEPTH + 1);

    res_t             mem [RES_FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = cnt_reg != '0;
    assign out_res   = mem[rd_ptr_reg];
    assign room2     = cnt_reg <= CNT_W'(RES_FIFO_DEPTH - 2);
    assign wr_ptr_next = wr_ptr_reg + PTR_W'(1);

    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            mem[wr_ptr_reg] <= push0;
        end
        if (push_cnt == 2'd2) begin
            mem[wr_ptr_next] <= push1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(push_cnt);
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            cnt_reg <= cnt_reg + CNT_W'(push_cnt) - CNT_W'(pop);
        end
    end

endmodule

`default_nettype wire

FILE: hdl/tape_audio_range_classifier.sv
// Top level of the tape audio range classifier: config registers, input stage,
// classification step and result queue. Depends on tarc_pkg, tarc_core, tarc_res_fifo.
`default_nettype none

// Splits a stream of signed 16-bit tape audio samples into ranges classed as data
// or silence. Each result gives the range's first index, the index one past its
// end, its pulse count (1 for silence), whether it is data, and whether it closes
// the stream; tlast marks the last result caused by one input sample. A sample
// with s_tlast set ends the stream: open ranges close and the next sample starts
// a new stream at index 0 (register values are kept). Rate: one sample per clock
// while the result queue has room for two results. A sample is registered on
// transfer and classified in a single pass once the queue has room; its results
// enter the four-entry result queue at the next edge and then transfer on the m_ side.
// s_tready drops only while a sample waits in the input register and the queue
// holds more than two results; a sample that closes two ranges needs two m_
// transfers to drain, so a stalled or slow m_ side is what holds the input back.
// The user must write registers only while the block is idle; the block does not enforce it.
module tape_audio_range_classifier #(
    parameter int INDEX_BITS = tarc_pkg::INDEX_BITS_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // configuration write port
    input  wire logic                               cfg_we,
    input  wire logic [tarc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire logic [tarc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // sample stream
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [15:0]                        s_tdata,   // [15:0] sample
    input  wire logic                               s_tlast,   // end of stream
    // range stream
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [95:0]                             m_tdata,   // [31:0] range_start,
                                                               // [63:32] range_end,
                                                               // [95:64] pulse_count
    output logic [1:0]                              m_tuser,   // [0] is_data,
                                                               // [1] stream_final
    output logic                                    m_tlast    // last_of_run
);
    import tarc_pkg::*;

    cfg_t                       cfg_reg;
    logic                       in_vld_reg;
    logic signed [SAMPLE_W-1:0] in_sample_reg;
    logic                       in_last_reg;
    logic                       step, room2;
    res_t                       res0, res1, out_res;
    logic [1:0]                 res_cnt;

    // Config registers; an index past the list is ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.quiet_level   <= QUIET_LEVEL_RST;
            cfg_reg.max_pulse_len <= MAX_PULSE_LEN_RST;
            cfg_reg.min_slope     <= MIN_SLOPE_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_QUIET_LEVEL:   cfg_reg.quiet_level   <= cfg_wdata[LEVEL_W-1:0];
                REG_MAX_PULSE_LEN: cfg_reg.max_pulse_len <= cfg_wdata[PLEN_W-1:0];
                REG_MIN_SLOPE:     cfg_reg.min_slope     <= cfg_wdata[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    // Input stage: the held sample steps once the queue has room for two results
    assign step     = in_vld_reg && room2;
    assign s_tready = !in_vld_reg || step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_sample_reg <= signed'(s_tdata);
            in_last_reg   <= s_tlast;
        end
    end

    tarc_core #(
        .INDEX_BITS (INDEX_BITS)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .step        (step),
        .sample      (in_sample_reg),
        .stream_end  (in_last_reg),
        .res0        (res0),
        .res1        (res1),
        .res_cnt     (res_cnt)
    );

    tarc_res_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push0     (res0),
        .push1     (res1),
        .push_cnt  (res_cnt),
        .room2     (room2),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {out_res.pulse_count, out_res.range_end, out_res.range_start};
    assign m_tuser = {out_res.stream_final, out_res.is_data};
    assign m_tlast = out_res.last_of_run;

endmodule

`default_nettype wire
